FILE: design/obgf_pkg.sv
// ----------------------------------------------------------------------------
// obgf_pkg
// Shared types and constants of the oriented box grid footprint pipeline.
// ----------------------------------------------------------------------------
package obgf_pkg;

  localparam int unsigned GridWidthDef  = 400;
  localparam int unsigned GridHeightDef = 400;

  localparam logic [1:0] ShapeBox      = 2'd0;
  localparam logic [1:0] ShapeSphere   = 2'd1;
  localparam logic [1:0] ShapeCylinder = 2'd2;
  localparam logic [1:0] ShapeNone     = 2'd3;

  localparam logic [1:0] CfgOriginX = 2'd0;
  localparam logic [1:0] CfgOriginY = 2'd1;
  localparam logic [1:0] CfgCellsPm = 2'd2;

  localparam logic [31:0] OriginResetVal = 32'hFFF6_0000;
  localparam logic [23:0] CpmResetVal    = 24'h14_0000;

  // Magnitudes of the first two rotation rows, the half extents, the position and the invalid flag.
  typedef struct packed {
    logic             inval;
    logic [2:0][23:0] h;
    logic [31:0]      px;
    logic [31:0]      py;
    logic [5:0][32:0] m;
  } rot_t;

  // Offsets from the grid origin in Q.44, already zero where not positive.
  typedef struct packed {
    logic             inval;
    logic [3:0][60:0] d;
  } dist_t;

endpackage

FILE: design/obgf_rot.sv
// ----------------------------------------------------------------------------
// obgf_rot
// Two stages: quaternion products, then rotation entries and magnitudes.
// ----------------------------------------------------------------------------
module obgf_rot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         shape_i,
  input  logic [23:0]        half_x_i,
  input  logic [23:0]        half_y_i,
  input  logic [23:0]        half_z_i,
  input  logic [31:0]        pos_x_i,
  input  logic [31:0]        pos_y_i,
  input  logic [15:0]        quat_w_i,
  input  logic [15:0]        quat_x_i,
  input  logic [15:0]        quat_y_i,
  input  logic [15:0]        quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output obgf_pkg::rot_t     out_o
);

  logic             v1_q, v2_q, adv1, adv2;
  logic             inval1_q;
  logic [2:0][23:0] h1_q;
  logic [31:0]      px1_q, py1_q;
  logic [8:0][31:0] p1_q, p1_d;
  logic [2:0][23:0] h_d;
  obgf_pkg::rot_t   r2_q, r2_d;
  logic signed [34:0] r [6];

  assign adv2       = !v2_q || out_ready_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    case (shape_i)
      obgf_pkg::ShapeBox:    h_d = {half_z_i, half_y_i, half_x_i};
      obgf_pkg::ShapeSphere: h_d = {half_x_i, half_x_i, half_x_i};
      default:               h_d = {half_y_i, half_x_i, half_x_i};
    endcase
    // Order: xx yy zz xy xz yz wx wy wz.
    p1_d[0] = $signed(quat_x_i) * $signed(quat_x_i);
    p1_d[1] = $signed(quat_y_i) * $signed(quat_y_i);
    p1_d[2] = $signed(quat_z_i) * $signed(quat_z_i);
    p1_d[3] = $signed(quat_x_i) * $signed(quat_y_i);
    p1_d[4] = $signed(quat_x_i) * $signed(quat_z_i);
    p1_d[5] = $signed(quat_y_i) * $signed(quat_z_i);
    p1_d[6] = $signed(quat_w_i) * $signed(quat_x_i);
    p1_d[7] = $signed(quat_w_i) * $signed(quat_y_i);
    p1_d[8] = $signed(quat_w_i) * $signed(quat_z_i);
  end

  always_comb begin
    logic signed [34:0] one;
    logic signed [34:0] s [9];
    one = 35'sd268435456;
    for (int i = 0; i < 9; i++) s[i] = 35'($signed(p1_q[i]));
    r[0] = one - ((s[1] + s[2]) <<< 1);
    r[1] = (s[3] - s[8]) <<< 1;
    r[2] = (s[4] + s[7]) <<< 1;
    r[3] = (s[3] + s[8]) <<< 1;
    r[4] = one - ((s[0] + s[2]) <<< 1);
    r[5] = (s[5] - s[6]) <<< 1;
    r2_d.inval = inval1_q;
    r2_d.h     = h1_q;
    r2_d.px    = px1_q;
    r2_d.py    = py1_q;
    for (int i = 0; i < 6; i++) begin
      r2_d.m[i] = r[i][34] ? 33'(-r[i]) : r[i][32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      inval1_q <= (shape_i == obgf_pkg::ShapeNone);
      h1_q     <= h_d;
      px1_q    <= pos_x_i;
      py1_q    <= pos_y_i;
      p1_q     <= p1_d;
    end
    if (adv2) r2_q <= r2_d;
  end

  assign out_valid_o = v2_q;
  assign out_o       = r2_q;

endmodule

FILE: design/obgf_ext.sv
// ----------------------------------------------------------------------------
// obgf_ext
// Three stages: extent products, extent sums with centre offsets, then the
// four bound offsets from the grid origin, clamped to zero where not positive.
// ----------------------------------------------------------------------------
module obgf_ext (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  obgf_pkg::rot_t  in_i,
  input  logic [31:0]     origin_x_i,
  input  logic [31:0]     origin_y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output obgf_pkg::dist_t out_o
);

  logic             va_q, vb_q, vc_q, adva, advb, advc;
  logic             inva_q, invb_q;
  logic [5:0][56:0] pa_q, pa_d;
  logic [31:0]      pxa_q, pya_q;
  logic [57:0]      exb_q, eyb_q;
  logic [32:0]      bxb_q, byb_q;
  obgf_pkg::dist_t  dc_q, dc_d;

  assign advc       = !vc_q || out_ready_i;
  assign advb       = !vb_q || advc;
  assign adva       = !va_q || advb;
  assign in_ready_o = adva;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pa_d[i] = 57'(in_i.m[i]) * 57'(in_i.h[i % 3]);
    end
  end

  always_comb begin
    logic signed [61:0] cx, cy, ex, ey;
    logic signed [61:0] dd [4];
    cx = 62'($signed(bxb_q)) <<< 28;
    cy = 62'($signed(byb_q)) <<< 28;
    ex = $signed({4'b0, exb_q});
    ey = $signed({4'b0, eyb_q});
    dd[0] = cx - ex;
    dd[1] = cx + ex;
    dd[2] = cy - ey;
    dd[3] = cy + ey;
    dc_d.inval = invb_q;
    for (int i = 0; i < 4; i++) begin
      dc_d.d[i] = (dd[i] > 62'sd0) ? dd[i][60:0] : 61'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (adva) va_q <= in_valid_i;
      if (advb) vb_q <= va_q;
      if (advc) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adva) begin
      inva_q <= in_i.inval;
      pa_q   <= pa_d;
      pxa_q  <= in_i.px;
      pya_q  <= in_i.py;
    end
    if (advb) begin
      invb_q <= inva_q;
      exb_q  <= 58'(pa_q[0]) + 58'(pa_q[1]) + 58'(pa_q[2]);
      eyb_q  <= 58'(pa_q[3]) + 58'(pa_q[4]) + 58'(pa_q[5]);
      bxb_q  <= $signed({pxa_q[31], pxa_q}) - $signed({origin_x_i[31], origin_x_i});
      byb_q  <= $signed({pya_q[31], pya_q}) - $signed({origin_y_i[31], origin_y_i});
    end
    if (advc) dc_q <= dc_d;
  end

  assign out_valid_o = vc_q;
  assign out_o       = dc_q;

endmodule

FILE: design/obgf_cell.sv
// ----------------------------------------------------------------------------
// obgf_cell
// Two stages: split scaling products, then the cell index with grid clamp.
// ----------------------------------------------------------------------------
module obgf_cell #(
  parameter int unsigned GRID_WIDTH  = obgf_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = obgf_pkg::GridHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  obgf_pkg::dist_t in_i,
  input  logic [23:0]     cells_per_metre_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [3:0][8:0] cell_o,
  output logic            footprint_valid_o
);

  localparam logic [24:0] XMax = 25'(GRID_WIDTH - 1);
  localparam logic [24:0] YMax = 25'(GRID_HEIGHT - 1);

  logic             va_q, vb_q, adva, advb;
  logic             inva_q;
  logic [3:0][55:0] lo_q;
  logic [3:0][52:0] hi_q;
  logic [3:0][8:0]  cell_q, cell_d;
  logic             fv_q;

  assign advb       = !vb_q || out_ready_i;
  assign adva       = !va_q || advb;
  assign in_ready_o = adva;

  always_comb begin
    logic [84:0] sum;
    logic [24:0] q, lim;
    for (int i = 0; i < 4; i++) begin
      sum = {hi_q[i], 32'd0} + 85'(lo_q[i]);
      q   = sum[84:60];
      lim = (i < 2) ? XMax : YMax;
      if (q > lim) q = lim;
      cell_d[i] = inva_q ? 9'd0 : q[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adva) va_q <= in_valid_i;
      if (advb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adva) begin
      inva_q <= in_i.inval;
      for (int i = 0; i < 4; i++) begin
        lo_q[i] <= 56'(in_i.d[i][31:0]) * 56'(cells_per_metre_i);
        hi_q[i] <= 53'(in_i.d[i][60:32]) * 53'(cells_per_metre_i);
      end
    end
    if (advb) begin
      cell_q <= cell_d;
      fv_q   <= !inva_q;
    end
  end

  assign out_valid_o       = vb_q;
  assign cell_o            = cell_q;
  assign footprint_valid_o = fv_q;

endmodule

FILE: design/oriented_box_grid_footprint_core.sv
// Throughput: one transaction per cycle while the output is accepted; each
// of the seven register stages holds its own item and only stalls while
// the stage after it is full.
// Reset clears the stage valid flags and restores the origin and scale
// registers; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// oriented_box_grid_footprint_core
// Grid cell rectangle covered by a rotated box, sphere or cylinder.
// ----------------------------------------------------------------------------
module oriented_box_grid_footprint_core #(
  parameter int unsigned GRID_WIDTH  = obgf_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = obgf_pkg::GridHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  shape_i,
  input  logic [23:0] half_x_i,
  input  logic [23:0] half_y_i,
  input  logic [23:0] half_z_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [15:0] quat_w_i,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  cell_x_first_o,
  output logic [8:0]  cell_x_last_o,
  output logic [8:0]  cell_y_first_o,
  output logic [8:0]  cell_y_last_o,
  output logic        footprint_valid_o
);

  logic [31:0]     origin_x_q, origin_y_q;
  logic [23:0]     cpm_q;
  logic            rot_valid, rot_ready, ext_valid, ext_ready;
  obgf_pkg::rot_t  rot;
  obgf_pkg::dist_t offs;
  logic [3:0][8:0] cell_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= obgf_pkg::OriginResetVal;
      origin_y_q <= obgf_pkg::OriginResetVal;
      cpm_q      <= obgf_pkg::CpmResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        obgf_pkg::CfgOriginX: origin_x_q <= cfg_wdata_i;
        obgf_pkg::CfgOriginY: origin_y_q <= cfg_wdata_i;
        obgf_pkg::CfgCellsPm: cpm_q      <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  obgf_rot u_rot (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .shape_i, .half_x_i, .half_y_i, .half_z_i, .pos_x_i, .pos_y_i,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_o       (rot)
  );

  obgf_ext u_ext (
    .clk_i, .rst_ni,
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_i        (rot),
    .origin_x_i  (origin_x_q),
    .origin_y_i  (origin_y_q),
    .out_valid_o (ext_valid),
    .out_ready_i (ext_ready),
    .out_o       (offs)
  );

  obgf_cell #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_cell (
    .clk_i, .rst_ni,
    .in_valid_i        (ext_valid),
    .in_ready_o        (ext_ready),
    .in_i              (offs),
    .cells_per_metre_i (cpm_q),
    .out_valid_o,
    .out_ready_i,
    .cell_o            (cell_idx),
    .footprint_valid_o
  );

  assign cell_x_first_o = cell_idx[0];
  assign cell_x_last_o  = cell_idx[1];
  assign cell_y_first_o = cell_idx[2];
  assign cell_y_last_o  = cell_idx[3];

endmodule
